>>> rtl/step_dir_positioner_backlash_macros.svh
// ----------------------------------------------------------------------------
// Step/direction positioner assertion macros
// Shared concurrent assertion forms for the positioner checkers.
// ----------------------------------------------------------------------------
`ifndef STEP_DIR_POSITIONER_BACKLASH_MACROS_SVH
`define STEP_DIR_POSITIONER_BACKLASH_MACROS_SVH

// Same-cycle implication, off during reset.
`define SDPB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdpb assertion failed");

// Next-cycle implication, off during reset.
`define SDPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdpb assertion failed");

// Next-cycle implication, checked through reset as well.
`define SDPB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sdpb assertion failed");

`endif

>>> rtl/sdpb_pkg.sv
// ----------------------------------------------------------------------------
// Step/direction positioner package
// Field widths, codes, reset values and shared types.
// ----------------------------------------------------------------------------
package sdpb_pkg;

    localparam int PosW   = 32;
    localparam int TickW  = 16;
    localparam int LevelW = 3;
    localparam int PwW    = 12;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_SET_TARGET = 2'd1,
        OP_SET_POS    = 2'd2
    } t_opcode;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INTERVAL   = 2'd0,
        CFG_BL_ENABLE  = 2'd1,
        CFG_BL_STEPS   = 2'd2,
        CFG_SPEED      = 2'd3
    } t_cfg_idx;

    localparam logic [TickW-1:0]  RST_INTERVAL  = 16'd1000;
    localparam logic              RST_BL_ENABLE = 1'b1;
    localparam logic [TickW-1:0]  RST_BL_STEPS  = 16'd300;
    localparam logic [LevelW-1:0] RST_SPEED     = 3'd0;

    localparam logic [PwW-1:0] PW_1000 = 12'd1000;
    localparam logic [PwW-1:0] PW_1500 = 12'd1500;
    localparam logic [PwW-1:0] PW_2000 = 12'd2000;
    localparam logic [PwW-1:0] PW_2500 = 12'd2500;
    localparam logic [PwW-1:0] PW_3000 = 12'd3000;

    localparam logic DIR_CW  = 1'b1;
    localparam logic DIR_CCW = 1'b0;

    typedef struct packed {
        logic [TickW-1:0]  interval;
        logic              bl_enable;
        logic [TickW-1:0]  bl_steps;
        logic [LevelW-1:0] speed;
    } t_cfg;

    typedef struct packed {
        logic                  step_pulse;
        logic                  step_dir;
        logic signed [PosW-1:0] position;
        logic                  moving;
        logic                  in_backlash;
        logic [PwW-1:0]        pulse_width_us;
    } t_result;

    function automatic logic [PwW-1:0] pulse_width(input logic [LevelW-1:0] level);
        logic [PwW-1:0] w;
        case (level)
            3'd0, 3'd1: w = PW_1000;
            3'd2:       w = PW_1500;
            3'd3:       w = PW_2000;
            3'd4:       w = PW_2500;
            default:    w = PW_3000;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/sdpb_in_if.sv
// ----------------------------------------------------------------------------
// Positioner command channel
// Valid/ready channel carrying opcode and position operand.
// ----------------------------------------------------------------------------
interface sdpb_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          opcode;
    logic signed [sdpb_pkg::PosW-1:0]    value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

>>> rtl/sdpb_out_if.sv
// ----------------------------------------------------------------------------
// Positioner result channel
// Valid/ready channel carrying step outputs and position.
// ----------------------------------------------------------------------------
interface sdpb_out_if;
    logic                                valid;
    logic                                ready;
    logic                                step_pulse;
    logic                                step_dir;
    logic signed [sdpb_pkg::PosW-1:0]    position;
    logic                                moving;
    logic                                in_backlash;
    logic [sdpb_pkg::PwW-1:0]            pulse_width_us;

    modport source (output valid, output step_pulse, output step_dir, output position,
                    output moving, output in_backlash, output pulse_width_us, input ready);
    modport sink   (input valid, input step_pulse, input step_dir, input position,
                    input moving, input in_backlash, input pulse_width_us, output ready);
endinterface

>>> rtl/sdpb_core.sv
// ----------------------------------------------------------------------------
// Positioner core
// Position, target, direction, step timer and backlash state; one item per
// transfer, result formed in the same cycle.
// ----------------------------------------------------------------------------
module sdpb_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [1:0]                       i_opcode,
    input  logic signed [sdpb_pkg::PosW-1:0] i_value,
    input  sdpb_pkg::t_cfg                   i_cfg,
    output sdpb_pkg::t_result                o_result
);

    logic signed [sdpb_pkg::PosW-1:0] r_cur_pos, n_cur_pos;
    logic signed [sdpb_pkg::PosW-1:0] r_tgt_pos, n_tgt_pos;
    logic                             r_last_dir, n_last_dir;
    logic [sdpb_pkg::TickW-1:0]       r_ticks, n_ticks;
    logic [sdpb_pkg::TickW-1:0]       r_bl_left, n_bl_left;

    logic [sdpb_pkg::TickW-1:0] ticks_inc;
    logic                       due;
    logic                       dir;
    logic                       pulse;
    logic                       bl_pulse;

    assign ticks_inc = (r_ticks < i_cfg.interval) ? r_ticks + 16'd1 : r_ticks;
    assign due       = ticks_inc >= i_cfg.interval;
    assign dir       = (r_tgt_pos > r_cur_pos) ? sdpb_pkg::DIR_CW : sdpb_pkg::DIR_CCW;

    always_comb begin
        n_cur_pos  = r_cur_pos;
        n_tgt_pos  = r_tgt_pos;
        n_last_dir = r_last_dir;
        n_ticks    = r_ticks;
        n_bl_left  = r_bl_left;
        pulse      = 1'b0;
        bl_pulse   = 1'b0;
        if (i_accept) begin
            case (i_opcode)
                sdpb_pkg::OP_SET_TARGET: begin
                    n_tgt_pos = i_value;
                end
                sdpb_pkg::OP_SET_POS: begin
                    n_cur_pos = i_value;
                end
                sdpb_pkg::OP_TICK: begin
                    if (r_bl_left != '0) begin
                        if (due) begin
                            n_bl_left = r_bl_left - 16'd1;
                            pulse     = 1'b1;
                            bl_pulse  = 1'b1;
                        end
                    end else if (r_cur_pos == r_tgt_pos) begin
                        n_last_dir = sdpb_pkg::DIR_CCW;
                    end else if (due) begin
                        pulse = 1'b1;
                        if (dir != r_last_dir) begin
                            n_last_dir = dir;
                            if (i_cfg.bl_enable && (i_cfg.bl_steps != '0)) begin
                                n_bl_left = i_cfg.bl_steps - 16'd1;
                                bl_pulse  = 1'b1;
                            end
                        end
                        if (!bl_pulse) begin
                            n_cur_pos = dir ? r_cur_pos + 32'sd1 : r_cur_pos - 32'sd1;
                        end
                    end
                    n_ticks = pulse ? '0 : ticks_inc;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_pos  <= '0;
            r_tgt_pos  <= '0;
            r_last_dir <= sdpb_pkg::DIR_CW;
            r_ticks    <= '0;
            r_bl_left  <= '0;
        end else begin
            r_cur_pos  <= n_cur_pos;
            r_tgt_pos  <= n_tgt_pos;
            r_last_dir <= n_last_dir;
            r_ticks    <= n_ticks;
            r_bl_left  <= n_bl_left;
        end
    end

    always_comb begin
        o_result.step_pulse     = pulse;
        o_result.step_dir       = n_last_dir;
        o_result.position       = n_cur_pos;
        o_result.moving         = (n_cur_pos != n_tgt_pos) || (n_bl_left != '0);
        o_result.in_backlash    = bl_pulse;
        o_result.pulse_width_us = sdpb_pkg::pulse_width(i_cfg.speed);
    end

endmodule

>>> rtl/step_dir_positioner_backlash.sv
// ----------------------------------------------------------------------------
// Step/direction positioner with backlash compensation
// A command's result is registered and shows on o_res in the cycle after its transfer.
// Throughput: one command per cycle; a command is taken while a result
// waits as long as that result transfers in the same cycle.
// Reset: synchronous, active low; position, target, timer and backlash clear,
// direction clockwise, registers to their defaults, no result pending.
// ----------------------------------------------------------------------------
module step_dir_positioner_backlash (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    sdpb_in_if.sink                              i_cmd,
    sdpb_out_if.source                           o_res,
    input  logic                                 i_cfg_wr_en,
    input  logic [sdpb_pkg::CfgIdxW-1:0]         i_cfg_idx,
    input  logic [sdpb_pkg::CfgDataW-1:0]        i_cfg_data
);

    sdpb_pkg::t_cfg    r_cfg;
    sdpb_pkg::t_result core_res;
    sdpb_pkg::t_result r_res;
    logic              r_out_valid;
    logic              accept;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval  <= sdpb_pkg::RST_INTERVAL;
            r_cfg.bl_enable <= sdpb_pkg::RST_BL_ENABLE;
            r_cfg.bl_steps  <= sdpb_pkg::RST_BL_STEPS;
            r_cfg.speed     <= sdpb_pkg::RST_SPEED;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                sdpb_pkg::CFG_INTERVAL:  r_cfg.interval  <= i_cfg_data;
                sdpb_pkg::CFG_BL_ENABLE: r_cfg.bl_enable <= i_cfg_data[0];
                sdpb_pkg::CFG_BL_STEPS:  r_cfg.bl_steps  <= i_cfg_data;
                sdpb_pkg::CFG_SPEED:     r_cfg.speed     <= i_cfg_data[sdpb_pkg::LevelW-1:0];
                default: begin
                end
            endcase
        end
    end

    sdpb_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_opcode (i_cmd.opcode),
        .i_value  (i_cmd.value),
        .i_cfg    (r_cfg),
        .o_result (core_res)
    );

    // hold the result until its transfer, load on each command transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= core_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.step_pulse     = r_res.step_pulse;
    assign o_res.step_dir       = r_res.step_dir;
    assign o_res.position       = r_res.position;
    assign o_res.moving         = r_res.moving;
    assign o_res.in_backlash    = r_res.in_backlash;
    assign o_res.pulse_width_us = r_res.pulse_width_us;

endmodule

>>> rtl/sdpb_checker.sv
// ----------------------------------------------------------------------------
// Positioner port checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "step_dir_positioner_backlash_macros.svh"

module sdpb_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic                             i_step_pulse,
    input logic                             i_in_backlash,
    input logic signed [sdpb_pkg::PosW-1:0] i_position,
    input logic [sdpb_pkg::PwW-1:0]         i_pulse_width_us
);

    logic in_xfer;

    assign in_xfer = i_in_valid && i_in_ready;

    `SDPB_ASSERT_NEXT_ALWAYS(a_rst_no_result, i_clk, !i_rst_n, !i_out_valid)

    `SDPB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready && !in_xfer, i_out_valid && $stable(i_position) && $stable(i_pulse_width_us))

    `SDPB_ASSERT_IMPLY(a_bl_is_pulse, i_clk, i_rst_n, i_out_valid && i_in_backlash, i_step_pulse)

    `SDPB_ASSERT_IMPLY(a_pw_legal, i_clk, i_rst_n, i_out_valid, (i_pulse_width_us == sdpb_pkg::PW_1000) || (i_pulse_width_us == sdpb_pkg::PW_1500) || (i_pulse_width_us == sdpb_pkg::PW_2000) || (i_pulse_width_us == sdpb_pkg::PW_2500) || (i_pulse_width_us == sdpb_pkg::PW_3000))

endmodule

bind step_dir_positioner_backlash sdpb_checker u_sdpb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_cmd.valid),
    .i_in_ready       (i_cmd.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_step_pulse     (o_res.step_pulse),
    .i_in_backlash    (o_res.in_backlash),
    .i_position       (o_res.position),
    .i_pulse_width_us (o_res.pulse_width_us)
);

>>> verif/step_dir_positioner_backlash_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step/direction positioner testbench
// Drives tick, target and position commands through the command channel and
// checks every result against an in-bench motor model or a table value. A
// short table covers reset values, position extremes, backlash on and off
// and the unused opcode. Random phases follow, each under new register
// values, with gaps on both channels and one long hold on the result side.
// ----------------------------------------------------------------------------
module step_dir_positioner_backlash_test;

    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam int         N_PHASES    = 8;
    localparam int         PHASE_CMDS  = 60;
    localparam int         HOLD_AT     = 200;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         MAX_REPORTS = 10;

    typedef struct packed {
        logic                 is_cfg;
        sdpb_pkg::t_cfg_idx   idx;
        logic [15:0]          data;
        logic [1:0]           op;
        logic [31:0]          val;
        logic                 has_exp;
        sdpb_pkg::t_result    exp;
    } t_row;

    localparam sdpb_pkg::t_result NO_EXP = '0;

    localparam t_row PLAN [24] = '{
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_SET_TARGET, 32'd0, 1'b1,
          '{1'b0, sdpb_pkg::DIR_CW, 32'sd0, 1'b0, 1'b0, sdpb_pkg::PW_1000}},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_TICK, 32'd0, 1'b1,
          '{1'b0, sdpb_pkg::DIR_CCW, 32'sd0, 1'b0, 1'b0, sdpb_pkg::PW_1000}},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, OP_NONE, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, sdpb_pkg::DIR_CCW, 32'sd0, 1'b0, 1'b0, sdpb_pkg::PW_1000}},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_SET_POS, 32'h7FFF_FFFF, 1'b1,
          '{1'b0, sdpb_pkg::DIR_CCW, 32'h7FFF_FFFF, 1'b1, 1'b0, sdpb_pkg::PW_1000}},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_SET_TARGET,
          32'h8000_0000, 1'b1,
          '{1'b0, sdpb_pkg::DIR_CCW, 32'h7FFF_FFFF, 1'b1, 1'b0, sdpb_pkg::PW_1000}},
        '{1'b1, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b1, sdpb_pkg::CFG_SPEED, 16'd7, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b1, sdpb_pkg::CFG_BL_STEPS, 16'd2, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_SET_TARGET,
          32'h7FFF_FFFF, 1'b0, NO_EXP},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b1, sdpb_pkg::CFG_BL_ENABLE, 16'd0, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_SET_TARGET,
          32'h8000_0000, 1'b0, NO_EXP},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b1, sdpb_pkg::CFG_BL_ENABLE, 16'd1, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b1, sdpb_pkg::CFG_BL_STEPS, 16'd0, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_SET_TARGET,
          32'h7FFF_FFFF, 1'b0, NO_EXP},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b1, sdpb_pkg::CFG_INTERVAL, 16'hFFFF, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b1, sdpb_pkg::CFG_SPEED, 16'd2, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, sdpb_pkg::OP_TICK, 32'd0, 1'b0, NO_EXP},
        '{1'b0, sdpb_pkg::CFG_INTERVAL, 16'd0, OP_NONE, 32'd0, 1'b0, NO_EXP}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [sdpb_pkg::CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [sdpb_pkg::CfgDataW-1:0] i_cfg_data = '0;

    sdpb_in_if  cmd ();
    sdpb_out_if res ();

    step_dir_positioner_backlash u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_res      (res),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // motor model state and registers
    logic [sdpb_pkg::PosW-1:0]   m_pos = '0;
    logic [sdpb_pkg::PosW-1:0]   m_target = '0;
    logic                        m_dir = sdpb_pkg::DIR_CW;
    logic [sdpb_pkg::TickW-1:0]  m_ticks = '0;
    logic [sdpb_pkg::TickW-1:0]  m_bl_left = '0;
    logic [sdpb_pkg::TickW-1:0]  m_interval = sdpb_pkg::RST_INTERVAL;
    logic                        m_bl_en = sdpb_pkg::RST_BL_ENABLE;
    logic [sdpb_pkg::TickW-1:0]  m_bl_steps = sdpb_pkg::RST_BL_STEPS;
    logic [sdpb_pkg::LevelW-1:0] m_speed = sdpb_pkg::RST_SPEED;

    sdpb_pkg::t_result pending_res [$];
    int n_cmds = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_writes = 0;
    int n_pulses = 0;
    int n_bl_pulses = 0;
    int cycles = 0;
    bit quiet_tx = 1'b0;
    logic rx_rdy = 1'b0;
    logic rx_hold = 1'b0;

    assign res.ready = rx_rdy && !rx_hold;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_res.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic sdpb_pkg::t_result advance_motor(input logic [1:0] op,
                                                        input logic [31:0] val);
        sdpb_pkg::t_result r;
        logic    pulse;
        logic    bl_pulse;
        logic    dir;
        pulse = 1'b0;
        bl_pulse = 1'b0;
        case (op)
            sdpb_pkg::OP_SET_TARGET: m_target = val;
            sdpb_pkg::OP_SET_POS:    m_pos = val;
            sdpb_pkg::OP_TICK: begin
                if (m_ticks < m_interval)
                    m_ticks = m_ticks + 1'b1;
                if (m_bl_left != '0) begin
                    if (m_ticks >= m_interval) begin
                        m_bl_left = m_bl_left - 1'b1;
                        pulse = 1'b1;
                        bl_pulse = 1'b1;
                    end
                end else if (m_pos == m_target) begin
                    m_dir = sdpb_pkg::DIR_CCW;
                end else if (m_ticks >= m_interval) begin
                    dir = ($signed(m_target) > $signed(m_pos)) ? sdpb_pkg::DIR_CW
                                                               : sdpb_pkg::DIR_CCW;
                    pulse = 1'b1;
                    if (dir != m_dir) begin
                        m_dir = dir;
                        if (m_bl_en && m_bl_steps != '0) begin
                            m_bl_left = m_bl_steps - 1'b1;
                            bl_pulse = 1'b1;
                        end
                    end
                    if (!bl_pulse)
                        m_pos = (dir == sdpb_pkg::DIR_CW) ? m_pos + 1'b1 : m_pos - 1'b1;
                end
                if (pulse)
                    m_ticks = '0;
            end
            default: ;
        endcase
        r.step_pulse = pulse;
        r.step_dir = m_dir;
        r.position = m_pos;
        r.moving = (m_pos != m_target) || (m_bl_left != '0);
        r.in_backlash = bl_pulse;
        case (m_speed)
            3'd0, 3'd1: r.pulse_width_us = sdpb_pkg::PW_1000;
            3'd2:       r.pulse_width_us = sdpb_pkg::PW_1500;
            3'd3:       r.pulse_width_us = sdpb_pkg::PW_2000;
            3'd4:       r.pulse_width_us = sdpb_pkg::PW_2500;
            default:    r.pulse_width_us = sdpb_pkg::PW_3000;
        endcase
        n_pulses += pulse;
        n_bl_pulses += bl_pulse;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input longint want, input longint got);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
            $display("mismatch in %s at result %0d: expected %0h, got %0h",
                     field, n_results, want, got);
    endtask

    // Called at a falling edge; owns the valid assignment of that edge.
    task automatic send_cmd(input logic [1:0] op, input logic [31:0] val,
                            input logic has_exp, input sdpb_pkg::t_result typed_exp);
        int                gap;
        sdpb_pkg::t_result want;
        gap = quiet_tx ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            cmd.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd.valid <= 1'b1;
        cmd.opcode <= op;
        cmd.value <= val;
        do @(posedge i_clk); while (!(cmd.valid && cmd.ready));
        want = advance_motor(op, val);
        pending_res.push_back(has_exp ? typed_exp : want);
        n_cmds++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        cmd.valid <= 1'b0;
        while (pending_res.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input sdpb_pkg::t_cfg_idx idx,
                             input logic [sdpb_pkg::CfgDataW-1:0] data);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            sdpb_pkg::CFG_INTERVAL:  m_interval = data;
            sdpb_pkg::CFG_BL_ENABLE: m_bl_en = data[0];
            sdpb_pkg::CFG_BL_STEPS:  m_bl_steps = data;
            sdpb_pkg::CFG_SPEED:     m_speed = data[sdpb_pkg::LevelW-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    // long hold on the result side while commands keep coming
    initial begin : result_hold
        wait (n_cmds >= HOLD_AT);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // result side: random stalls and recurring quiet windows
    initial begin : result_sink
        int                stall;
        sdpb_pkg::t_result got;
        sdpb_pkg::t_result want;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if ((n_results / 40) % 3 == 1) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 12);
            end
            if (stall > 0) begin
                rx_rdy <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rx_rdy <= 1'b1;
            do @(posedge i_clk); while (!(res.valid && res.ready));
            got.step_pulse = res.step_pulse;
            got.step_dir = res.step_dir;
            got.position = res.position;
            got.moving = res.moving;
            got.in_backlash = res.in_backlash;
            got.pulse_width_us = res.pulse_width_us;
            if (pending_res.size() == 0) begin
                note_mismatch("unexpected transfer, position", 0, got.position);
            end else begin
                want = pending_res.pop_front();
                if (got.step_pulse !== want.step_pulse)
                    note_mismatch("step_pulse", want.step_pulse, got.step_pulse);
                if (got.step_dir !== want.step_dir)
                    note_mismatch("step_dir", want.step_dir, got.step_dir);
                if (got.position !== want.position)
                    note_mismatch("position", want.position, got.position);
                if (got.moving !== want.moving)
                    note_mismatch("moving", want.moving, got.moving);
                if (got.in_backlash !== want.in_backlash)
                    note_mismatch("in_backlash", want.in_backlash, got.in_backlash);
                if (got.pulse_width_us !== want.pulse_width_us)
                    note_mismatch("pulse_width_us", want.pulse_width_us,
                                  got.pulse_width_us);
            end
            n_results++;
            @(negedge i_clk);
        end
    end

    initial begin : command_source
        int          pick;
        logic [1:0]  op;
        logic [31:0] val;
        cmd.valid = 1'b0;
        cmd.opcode = sdpb_pkg::OP_TICK;
        cmd.value = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (PLAN[k]) begin
            if (PLAN[k].is_cfg)
                write_reg(PLAN[k].idx, PLAN[k].data);
            else
                send_cmd(PLAN[k].op, PLAN[k].val, PLAN[k].has_exp, PLAN[k].exp);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(sdpb_pkg::CFG_INTERVAL, (p == 2) ? 16'($urandom_range(5, 20))
                                                       : 16'($urandom_range(0, 3)));
            write_reg(sdpb_pkg::CFG_BL_ENABLE, (p == N_PHASES - 1) ? 16'd1
                                                    : 16'($urandom_range(0, 1)));
            // hold the huge backlash count for the end, it never drains
            write_reg(sdpb_pkg::CFG_BL_STEPS, (p == N_PHASES - 1) ? 16'hFFFF
                                                   : 16'($urandom_range(0, 4)));
            write_reg(sdpb_pkg::CFG_SPEED, 16'($urandom_range(0, 7)));
            quiet_tx = (p % 3 == 1);
            for (int i = 0; i < PHASE_CMDS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    op = sdpb_pkg::OP_TICK;
                    val = $urandom;
                end else if (pick < 80) begin
                    op = sdpb_pkg::OP_SET_TARGET;
                    val = m_pos + 32'($urandom_range(0, 12)) - 32'd6;
                end else if (pick < 87) begin
                    op = sdpb_pkg::OP_SET_POS;
                    val = m_target + 32'($urandom_range(0, 8)) - 32'd4;
                end else if (pick < 93) begin
                    op = sdpb_pkg::OP_SET_TARGET;
                    val = $urandom;
                end else if (pick < 97) begin
                    op = sdpb_pkg::OP_SET_POS;
                    val = $urandom;
                end else begin
                    op = OP_NONE;
                    val = $urandom;
                end
                send_cmd(op, val, 1'b0, NO_EXP);
            end
        end

        wait_idle();
        $display("%0d commands sent, %0d results checked, %0d register writes",
                 n_cmds, n_results, n_writes);
        $display("%0d step pulses predicted, %0d of them backlash", n_pulses, n_bl_pulses);
        if (n_mismatch == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sdpb_pkg.sv
rtl/sdpb_in_if.sv
rtl/sdpb_out_if.sv
rtl/sdpb_core.sv
rtl/step_dir_positioner_backlash.sv
rtl/sdpb_checker.sv
verif/step_dir_positioner_backlash_test.sv
